/* src/load_store_order_checker_top_macros.svh */
// assertion macros shared by the load/store order checker rtl
// expects clock and reset to be visible in the scope of each use
`ifndef LOAD_STORE_ORDER_CHECKER_TOP_MACROS_SVH
`define LOAD_STORE_ORDER_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define LSOC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lsoc_pkg.sv */
// shared types and codes for the load/store order checker
// no dependencies
package lsoc_pkg;

   localparam int LSOC_QUEUE_DEPTH = 16;
   localparam int LSOC_TAG_BITS    = 8;
   localparam int LSOC_WORD_BITS   = 30;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_EXECUTE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_DUP       = 2'd3;

   localparam logic KIND_REPLAY = 1'b0;
   localparam logic KIND_DONE   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SCAN,
      S_COMPACT,
      S_DONE
   } lsoc_state_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic       needs_replay;
      logic       forwarded;
      logic       last;
   } rsp_ctrl_type;

endpackage

/* src/lsoc_rsp_reg.sv */
// output register of the result channel, one item deep
// depends on lsoc_pkg for the result control struct
module lsoc_rsp_reg
   import lsoc_pkg::*;
#(
   parameter int TAG_BITS = LSOC_TAG_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rsp_ctrl_type        push_ctrl,
   input  logic [TAG_BITS-1:0] push_tag,
   output logic                push_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [TAG_BITS-1:0] rsp_replay_tag,
   output logic [1:0]          rsp_status,
   output logic                rsp_needs_replay,
   output logic                rsp_forwarded,
   output logic                rsp_last
);

   logic                valid_ff, valid_in;
   rsp_ctrl_type        ctrl_ff, ctrl_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // a new item may land when the slot is empty or drains this cycle
   assign push_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      ctrl_in  = ctrl_ff;
      tag_in   = tag_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
         ctrl_in  = push_ctrl;
         tag_in   = push_tag;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      tag_ff  <= tag_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = ctrl_ff.kind;
   assign rsp_replay_tag   = tag_ff;
   assign rsp_status       = ctrl_ff.status;
   assign rsp_needs_replay = ctrl_ff.needs_replay;
   assign rsp_forwarded    = ctrl_ff.forwarded;
   assign rsp_last         = ctrl_ff.last;

endmodule

/* src/load_store_order_checker_top.sv */
// Load/store queue ordering checker. Takes one operation per request: insert an in-flight memory
// instruction in program order, execute it (mark resolved and scan same-word entries youngest
// first for replays and store forwarding), or remove it. Entries live in an entry memory
// (tag, word, store, resolved) and a program-order memory that maps rank to slot, both with
// registered reads. Inserts, removes and live executes first sweep the entry memory one slot per
// cycle to look up their tag, stopping at a hit. An execute that finds its tag then scans one rank
// per cycle in a pipeline, frozen while a stalled result channel cannot take a replay, and a
// remove that finds its tag compacts the order memory. Dead executes and the unused opcode skip
// the lookup and go straight to completion. Every request ends with one completion transfer,
// preceded by one replay transfer per younger resolved load found.
// Depends on lsoc_pkg, lsoc_rsp_reg and the assertion macro header.
`include "load_store_order_checker_top_macros.svh"

module load_store_order_checker_top
   import lsoc_pkg::*;
#(
   parameter int QUEUE_DEPTH = LSOC_QUEUE_DEPTH,
   parameter int TAG_BITS    = LSOC_TAG_BITS,
   parameter int WORD_BITS   = LSOC_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [TAG_BITS-1:0]  req_instr_tag,
   input  logic [WORD_BITS-1:0] req_word_addr,
   input  logic                 req_is_store,
   input  logic                 req_is_dead,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [TAG_BITS-1:0]  rsp_replay_tag,
   output logic [1:0]           rsp_status,
   output logic                 rsp_needs_replay,
   output logic                 rsp_forwarded,
   output logic                 rsp_last
);

   localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_BITS  = TAG_BITS + WORD_BITS + 2;
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(QUEUE_DEPTH);

   lsoc_state_type state_ff, state_in;

   logic [1:0]             op_ff, op_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic                   store_ff, store_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0]    live_cnt_ff, live_cnt_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   s1_v_ff, s1_v_in;
   logic [SLOT_BITS-1:0]   s1_idx_ff, s1_idx_in;
   logic                   s2_v_ff, s2_v_in;
   logic [SLOT_BITS-1:0]   s2_slot_ff, s2_slot_in;
   logic [SLOT_BITS-1:0]   self_slot_ff, self_slot_in;
   logic                   younger_ff, younger_in;
   logic                   replay_ff, replay_in;
   logic                   fwd_ff, fwd_in;
   logic                   found_ff, found_in;
   logic [1:0]             status_ff, status_in;

   // entry memory {tag, word, store, resolved} and rank-to-slot order memory
   logic [ENT_BITS-1:0]  ent_mem [QUEUE_DEPTH];
   logic [ENT_BITS-1:0]  ent_rdata_ff;
   logic                 ent_re, ent_we;
   logic [SLOT_BITS-1:0] ent_ra, ent_wa;
   logic [ENT_BITS-1:0]  ent_wd;
   logic [SLOT_BITS-1:0] ord_mem [QUEUE_DEPTH];
   logic [SLOT_BITS-1:0] ord_rdata_ff;
   logic                 ord_re, ord_we;
   logic [SLOT_BITS-1:0] ord_ra, ord_wa, ord_wd;

   logic                 req_accept;
   logic [TAG_BITS-1:0]  ent_tag;
   logic [WORD_BITS-1:0] ent_word;
   logic                 ent_store, ent_res;
   logic                 find_hit, find_end, queue_full;
   logic [SLOT_BITS-1:0] free_slot;
   logic                 eval, ent_match, is_self;
   logic                 replay_hit, fwd_hit, self_hit;
   logic                 adv, scan_end, comp_end;
   logic [CNT_BITS-1:0]  cnt_m1;
   logic                 push_valid, push_ready;
   rsp_ctrl_type         push_ctrl;
   logic [TAG_BITS-1:0]  push_tag;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign ent_tag   = ent_rdata_ff[ENT_BITS-1 -: TAG_BITS];
   assign ent_word  = ent_rdata_ff[WORD_BITS+1:2];
   assign ent_store = ent_rdata_ff[1];
   assign ent_res   = ent_rdata_ff[0];

   // tag lookup, one slot per cycle
   assign find_hit   = s1_v_ff && valid_ff[s1_idx_ff] && (ent_tag == tag_ff);
   assign find_end   = (state_ff == S_FIND) && s1_v_ff && (find_hit || s1_idx_ff == SLOT_LAST);
   assign queue_full = (live_cnt_ff == CNT_FULL);

   always_comb begin
      free_slot = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_BITS'(i);
         end
      end
   end

   // scan evaluation on the entry read back at stage two
   assign eval       = (state_ff == S_SCAN) && s2_v_ff && !fwd_ff;
   assign ent_match  = (ent_word == word_ff);
   assign is_self    = (s2_slot_ff == self_slot_ff);
   assign self_hit   = eval && ent_match && is_self;
   assign replay_hit = eval && ent_match && !is_self && ent_res && younger_ff && !ent_store;
   assign fwd_hit    = eval && ent_match && !is_self && ent_res && !younger_ff
                       && !store_ff && ent_store;
   // a replay that cannot be handed over freezes the whole scan pipeline
   assign adv        = !(replay_hit && !push_ready);
   assign scan_end   = fwd_ff || (cnt_ff == '0 && !s1_v_ff && !s2_v_ff);
   assign comp_end   = (cnt_ff == live_cnt_ff) && !s1_v_ff;
   assign cnt_m1     = cnt_ff - CNT_BITS'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if ((req_opcode == OP_EXECUTE && req_is_dead) || req_opcode == OP_NONE) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (find_end) begin
               if (op_ff == OP_EXECUTE && find_hit) begin
                  state_in = S_SCAN;
               end else if (op_ff == OP_REMOVE && find_hit) begin
                  state_in = S_COMPACT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_COMPACT: begin
            if (comp_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      tag_in       = tag_ff;
      word_in      = word_ff;
      store_in     = store_ff;
      valid_in     = valid_ff;
      live_cnt_in  = live_cnt_ff;
      cnt_in       = cnt_ff;
      s1_v_in      = 1'b0;
      s1_idx_in    = s1_idx_ff;
      s2_v_in      = 1'b0;
      s2_slot_in   = s2_slot_ff;
      self_slot_in = self_slot_ff;
      younger_in   = younger_ff;
      replay_in    = replay_ff;
      fwd_in       = fwd_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      ent_re       = 1'b0;
      ent_ra       = '0;
      ent_we       = 1'b0;
      ent_wa       = '0;
      ent_wd       = '0;
      ord_re       = 1'b0;
      ord_ra       = '0;
      ord_we       = 1'b0;
      ord_wa       = '0;
      ord_wd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in      = req_opcode;
               tag_in     = req_instr_tag;
               word_in    = req_word_addr;
               store_in   = req_is_store;
               cnt_in     = '0;
               younger_in = 1'b1;
               replay_in  = 1'b0;
               fwd_in     = 1'b0;
               found_in   = 1'b0;
               status_in  = STAT_OK;
            end
         end
         S_FIND: begin
            if (cnt_ff != CNT_FULL && !find_end) begin
               ent_re    = 1'b1;
               ent_ra    = cnt_ff[SLOT_BITS-1:0];
               s1_v_in   = 1'b1;
               s1_idx_in = cnt_ff[SLOT_BITS-1:0];
               cnt_in    = cnt_ff + CNT_BITS'(1);
            end
            if (find_end) begin
               cnt_in = (op_ff == OP_EXECUTE) ? live_cnt_ff : '0;
               case (op_ff)
                  OP_INSERT: begin
                     if (find_hit) begin
                        status_in = STAT_DUP;
                     end else if (queue_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ent_we              = 1'b1;
                        ent_wa              = free_slot;
                        ent_wd              = {tag_ff, word_ff, store_ff, 1'b0};
                        // new entry is the youngest rank
                        ord_we              = 1'b1;
                        ord_wa              = live_cnt_ff[SLOT_BITS-1:0];
                        ord_wd              = free_slot;
                        valid_in[free_slot] = 1'b1;
                        live_cnt_in         = live_cnt_ff + CNT_BITS'(1);
                     end
                  end
                  OP_EXECUTE: begin
                     if (find_hit) begin
                        self_slot_in = s1_idx_ff;
                        word_in      = ent_word;
                        store_in     = ent_store;
                        ent_we       = 1'b1;
                        ent_wa       = s1_idx_ff;
                        ent_wd       = {ent_rdata_ff[ENT_BITS-1:1], 1'b1};
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  OP_REMOVE: begin
                     if (find_hit) begin
                        self_slot_in        = s1_idx_ff;
                        valid_in[s1_idx_ff] = 1'b0;
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (adv) begin
               // stage one: rank to slot, youngest rank first
               if (cnt_ff != '0 && !fwd_ff) begin
                  ord_re  = 1'b1;
                  ord_ra  = cnt_m1[SLOT_BITS-1:0];
                  cnt_in  = cnt_m1;
                  s1_v_in = 1'b1;
               end
               // stage two: slot to entry
               if (s1_v_ff) begin
                  ent_re     = 1'b1;
                  ent_ra     = ord_rdata_ff;
                  s2_v_in    = 1'b1;
                  s2_slot_in = ord_rdata_ff;
               end
               if (self_hit) begin
                  younger_in = 1'b0;
               end
               if (replay_hit) begin
                  replay_in = 1'b1;
               end
               if (fwd_hit) begin
                  fwd_in = 1'b1;
               end
            end else begin
               s1_v_in = s1_v_ff;
               s2_v_in = s2_v_ff;
            end
         end
         S_COMPACT: begin
            if (cnt_ff != live_cnt_ff) begin
               ord_re    = 1'b1;
               ord_ra    = cnt_ff[SLOT_BITS-1:0];
               s1_v_in   = 1'b1;
               s1_idx_in = cnt_ff[SLOT_BITS-1:0];
               cnt_in    = cnt_ff + CNT_BITS'(1);
            end
            // ranks behind the removed entry move down by one
            if (s1_v_ff) begin
               if (ord_rdata_ff == self_slot_ff) begin
                  found_in = 1'b1;
               end else if (found_ff) begin
                  ord_we = 1'b1;
                  ord_wa = s1_idx_ff - SLOT_BITS'(1);
                  ord_wd = ord_rdata_ff;
               end
            end
            if (comp_end) begin
               live_cnt_in = live_cnt_ff - CNT_BITS'(1);
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         live_cnt_ff <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         live_cnt_ff <= live_cnt_in;
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      word_ff      <= word_in;
      store_ff     <= store_in;
      cnt_ff       <= cnt_in;
      s1_idx_ff    <= s1_idx_in;
      s2_slot_ff   <= s2_slot_in;
      self_slot_ff <= self_slot_in;
      younger_ff   <= younger_in;
      replay_ff    <= replay_in;
      fwd_ff       <= fwd_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      if (ent_re) begin
         ent_rdata_ff <= ent_mem[ent_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_wa] <= ord_wd;
      end
      if (ord_re) begin
         ord_rdata_ff <= ord_mem[ord_ra];
      end
   end

   // completion in the done state, replay transfers during the scan
   always_comb begin
      push_valid = (state_ff == S_DONE) || replay_hit;
      if (state_ff == S_DONE) begin
         push_ctrl.kind         = KIND_DONE;
         push_ctrl.status       = status_ff;
         push_ctrl.needs_replay = replay_ff;
         push_ctrl.forwarded    = fwd_ff;
         push_ctrl.last         = 1'b1;
         push_tag               = '0;
      end else begin
         push_ctrl.kind         = KIND_REPLAY;
         push_ctrl.status       = STAT_OK;
         push_ctrl.needs_replay = 1'b0;
         push_ctrl.forwarded    = 1'b0;
         push_ctrl.last         = 1'b0;
         push_tag               = ent_tag;
      end
   end

   lsoc_rsp_reg #(
      .TAG_BITS(TAG_BITS)
   ) u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .push_valid       (push_valid),
      .push_ctrl        (push_ctrl),
      .push_tag         (push_tag),
      .push_ready       (push_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_replay_tag   (rsp_replay_tag),
      .rsp_status       (rsp_status),
      .rsp_needs_replay (rsp_needs_replay),
      .rsp_forwarded    (rsp_forwarded),
      .rsp_last         (rsp_last)
   );

   `LSOC_ASSERT_IMPLY(a_live_count, state_ff != S_COMPACT, $countones(valid_ff) == live_cnt_ff, "live count out of step with valid bits")
   `LSOC_ASSERT_NEXT(a_replay_held, replay_hit && !push_ready, replay_hit && $stable(s2_slot_ff), "blocked replay lost")
   `LSOC_ASSERT_NEXT(a_fwd_stops, state_ff == S_SCAN && fwd_ff, state_ff == S_DONE, "scan continued past forwarding store")
   `LSOC_ASSERT_IMPLY(a_idle_empty, state_ff == S_IDLE, !s1_v_ff && !s2_v_ff, "pipeline busy while idle")

endmodule
